[sv/ati_pkg.sv]
// ati_pkg: types, widths and index tables shared by the affine transform inverter
// no dependencies; imported by affine_transform_inverse
package ati_pkg;

    // field and bus widths
    localparam int W       = 32;
    localparam int NFLD    = 12;
    localparam int NLANE   = 9;
    localparam int BUS_W   = NFLD * W;
    localparam int EPS_W   = 17;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    // exact intermediate widths: cofactor, determinant, determinant magnitude
    localparam int CW       = 64;
    localparam int DW       = 98;
    localparam int DMW      = 97;
    // quotient bits kept by the divider, one more than the result word
    localparam int DIV_BITS = W + 1;

    typedef logic signed [W-1:0]  word_t;
    typedef logic signed [CW-1:0] prod_t;

    // status traveling with each item through the divider
    typedef struct packed {
        logic             sing;
        logic [NLANE-1:0] neg;
        logic [NLANE-1:0] ovf;
    } div_flags_t;

    // matrix entry (row r, column c) sits at field c*3+r
    // cofactor p = x[PA]*x[PB] - x[MA]*x[MB]
    localparam int PA_IDX [NLANE] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
    localparam int PB_IDX [NLANE] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
    localparam int MA_IDX [NLANE] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int MB_IDX [NLANE] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

    // first row entries a00, a01, a02
    localparam int ROW0_IDX [3] = '{0, 3, 6};

    // column of each inverse lane, and diagonal lanes
    localparam int LANE_COL [NLANE] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
    localparam logic LANE_DIAG [NLANE] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

endpackage

[sv/affine_transform_inverse.sv]
// affine_transform_inverse: pipelined inverse of a 3x3 linear part plus origin
// depends on ati_pkg
//
// Takes one affine transform per clock when not stalled and returns its inverse,
// entries and translation in signed fixed point with FRAC_BITS fraction bits,
// saturated to 32 bits. A transform whose determinant magnitude is below
// det_epsilon (cfg port) returns the identity with zero translation. The pipeline
// is 9 stages of products, cofactors and the exact determinant, 33 restoring
// divider stages (one quotient bit per stage for all nine entries) and 3 stages
// of rounding and translation, then the output register. A stalled output holds
// the pipeline only once its last stage is full.
module affine_transform_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // u_x u_y u_z v_x v_y v_z w_x w_y w_z org_x org_y org_z, 32 bits each
    input  logic [ati_pkg::BUS_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // inv_u_x .. inv_w_z inv_org_x inv_org_y inv_org_z, 32 bits each
    output logic [ati_pkg::BUS_W-1:0]   m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ati_pkg::EPS_W-1:0]   cfg_data
);
    import ati_pkg::*;

    localparam int F2        = 2 * FRAC_BITS;
    localparam int NW        = ((CW + F2 > DMW) ? CW + F2 : DMW) + 1;
    localparam int XW        = (NW > DMW + DIV_BITS + 1) ? NW : DMW + DIV_BITS + 1;
    localparam int NSTG      = 9 + DIV_BITS + 3;
    localparam int LAST      = NSTG - 1;
    localparam int ORG_DEPTH = NSTG - 2;
    localparam int TSW       = 2 * W + 2;
    localparam int TRW       = TSW + 1;

    localparam logic [DIV_BITS-1:0] NEG_LIM = DIV_BITS'(1) << (W - 1);
    localparam logic [DIV_BITS-1:0] POS_LIM = NEG_LIM - DIV_BITS'(1);
    localparam word_t W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam word_t W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam word_t IDENT = word_t'(W'(1) << FRAC_BITS);
    localparam logic signed [TRW-1:0] RND = TRW'(1) << (FRAC_BITS - 1);

    // handshake and global stage enable
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic            m_tvalid_reg;
    logic            out_ready;
    logic            en;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign en        = !vld_reg[LAST] || out_ready;
    assign s_tready  = en;
    assign m_tvalid  = m_tvalid_reg;
    assign vld_next  = {vld_reg[NSTG-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // epsilon register
    logic [EPS_W-1:0] eps_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_valid) begin
            eps_reg <= cfg_data;
        end
    end

    // front stages: products, cofactors, determinant
    word_t                  mat_reg [9];
    word_t                  org_reg [ORG_DEPTH][3];
    prod_t                  pp_reg [NLANE];
    prod_t                  pm_reg [NLANE];
    word_t                  a0_reg1 [3];
    word_t                  a0_reg2 [3];
    prod_t                  cof_reg2 [NLANE];
    prod_t                  cof_reg3 [NLANE];
    prod_t                  cof_reg4 [NLANE];
    prod_t                  cof_reg5 [NLANE];
    logic signed [CW-1:0]   dh_reg [3];
    logic signed [CW:0]     dl_reg [3];
    logic signed [DW-1:0]   dt_reg [3];
    logic signed [DW-1:0]   det_reg;
    logic [DMW-1:0]         dmag_reg;
    logic                   dneg_reg;
    logic [CW-1:0]          cmag_reg [NLANE];
    logic [NLANE-1:0]       cneg_reg;
    logic [NW-1:0]          num_reg [NLANE];
    logic [DMW-1:0]         dvs_reg7;
    div_flags_t             flg_reg7;

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 0: capture transaction
            for (int f = 0; f < 9; f++) begin
                mat_reg[f] <= s_tdata[f*W +: W];
            end
            for (int c = 0; c < 3; c++) begin
                org_reg[0][c] <= s_tdata[(9+c)*W +: W];
            end
            for (int k = 1; k < ORG_DEPTH; k++) begin
                org_reg[k] <= org_reg[k-1];
            end
            // stage 1: eighteen products
            for (int p = 0; p < NLANE; p++) begin
                pp_reg[p] <= mat_reg[PA_IDX[p]] * mat_reg[PB_IDX[p]];
                pm_reg[p] <= mat_reg[MA_IDX[p]] * mat_reg[MB_IDX[p]];
            end
            for (int j = 0; j < 3; j++) begin
                a0_reg1[j] <= mat_reg[ROW0_IDX[j]];
            end
            // stage 2: exact cofactors
            for (int p = 0; p < NLANE; p++) begin
                cof_reg2[p] <= pp_reg[p] - pm_reg[p];
            end
            a0_reg2 <= a0_reg1;
            // stage 3: split first row times cofactor into high and low halves
            for (int j = 0; j < 3; j++) begin
                dh_reg[j] <= a0_reg2[j] * $signed(cof_reg2[j][CW-1:W]);
                dl_reg[j] <= a0_reg2[j] * $signed({1'b0, cof_reg2[j][W-1:0]});
            end
            cof_reg3 <= cof_reg2;
            // stage 4: recombine halves
            for (int j = 0; j < 3; j++) begin
                dt_reg[j] <= (DW'(dh_reg[j]) <<< W) + DW'(dl_reg[j]);
            end
            cof_reg4 <= cof_reg3;
            // stage 5: determinant
            det_reg  <= dt_reg[0] + dt_reg[1] + dt_reg[2];
            cof_reg5 <= cof_reg4;
            // stage 6: magnitudes and signs
            dneg_reg <= det_reg[DW-1];
            dmag_reg <= det_reg[DW-1] ? DMW'(-det_reg) : DMW'(det_reg);
            for (int p = 0; p < NLANE; p++) begin
                cneg_reg[p] <= cof_reg5[p][CW-1];
                cmag_reg[p] <= cof_reg5[p][CW-1] ? CW'(-cof_reg5[p]) : CW'(cof_reg5[p]);
            end
            // stage 7: rounded numerators and singular test
            for (int p = 0; p < NLANE; p++) begin
                num_reg[p] <= (NW'(cmag_reg[p]) << F2) + NW'(dmag_reg >> 1);
            end
            dvs_reg7      <= dmag_reg;
            flg_reg7.sing <= (dmag_reg == '0) || (dmag_reg < (DMW'(eps_reg) << F2));
            flg_reg7.neg  <= cneg_reg ^ {NLANE{dneg_reg}};
            flg_reg7.ovf  <= '0;
        end
    end

    // divider: entry stage checks overflow, then one quotient bit per stage
    logic [XW-1:0]       rem_reg [DIV_BITS+1][NLANE];
    logic [DIV_BITS-1:0] quo_reg [DIV_BITS+1][NLANE];
    logic [DMW-1:0]      dvs_reg [DIV_BITS+1];
    div_flags_t          flg_reg [DIV_BITS+1];
    logic [XW-1:0]       rem_next [DIV_BITS+1][NLANE];
    logic [DIV_BITS-1:0] quo_next [DIV_BITS+1][NLANE];
    logic [XW-1:0]       dsh [DIV_BITS+1];
    logic [NLANE-1:0]    ovf_next;

    always_comb begin
        for (int p = 0; p < NLANE; p++) begin
            ovf_next[p] = XW'(num_reg[p]) >= (XW'(dvs_reg7) << DIV_BITS);
        end
        dsh[0] = '0;
        for (int p = 0; p < NLANE; p++) begin
            rem_next[0][p] = '0;
            quo_next[0][p] = '0;
        end
        for (int k = 1; k <= DIV_BITS; k++) begin
            dsh[k] = XW'(dvs_reg[k-1]) << (DIV_BITS - k);
            for (int p = 0; p < NLANE; p++) begin
                if (rem_reg[k-1][p] >= dsh[k]) begin
                    rem_next[k][p] = rem_reg[k-1][p] - dsh[k];
                    quo_next[k][p] = {quo_reg[k-1][p][DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_next[k][p] = rem_reg[k-1][p];
                    quo_next[k][p] = {quo_reg[k-1][p][DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 8: divider entry
            for (int p = 0; p < NLANE; p++) begin
                rem_reg[0][p] <= XW'(num_reg[p]);
                quo_reg[0][p] <= '0;
            end
            dvs_reg[0]      <= dvs_reg7;
            flg_reg[0].sing <= flg_reg7.sing;
            flg_reg[0].neg  <= flg_reg7.neg;
            flg_reg[0].ovf  <= ovf_next;
            // stages 9 to 41: quotient bits, most significant first
            for (int k = 1; k <= DIV_BITS; k++) begin
                for (int p = 0; p < NLANE; p++) begin
                    rem_reg[k][p] <= rem_next[k][p];
                    quo_reg[k][p] <= quo_next[k][p];
                end
                dvs_reg[k] <= dvs_reg[k-1];
                flg_reg[k] <= flg_reg[k-1];
            end
        end
    end

    // back stages: saturation, translation products and sums
    word_t                  res_next [NLANE];
    word_t                  res_reg42 [NLANE];
    word_t                  res_reg43 [NLANE];
    word_t                  res_reg44 [NLANE];
    logic                   sing_reg42;
    logic                   sing_reg43;
    logic                   sing_reg44;
    prod_t                  tp_reg [NLANE];
    logic signed [TSW-1:0]  ts_reg [3];

    always_comb begin
        for (int p = 0; p < NLANE; p++) begin
            if (flg_reg[DIV_BITS].sing) begin
                res_next[p] = LANE_DIAG[p] ? IDENT : '0;
            end else if (flg_reg[DIV_BITS].ovf[p]) begin
                res_next[p] = flg_reg[DIV_BITS].neg[p] ? W_MIN : W_MAX;
            end else if (flg_reg[DIV_BITS].neg[p]) begin
                res_next[p] = (quo_reg[DIV_BITS][p] > NEG_LIM) ? W_MIN :
                              word_t'(W'(DIV_BITS'(0) - quo_reg[DIV_BITS][p]));
            end else begin
                res_next[p] = (quo_reg[DIV_BITS][p] > POS_LIM) ? W_MAX :
                              word_t'(quo_reg[DIV_BITS][p][W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 42: signed, saturated inverse entries
            res_reg42  <= res_next;
            sing_reg42 <= flg_reg[DIV_BITS].sing;
            // stage 43: inverse entries times origin
            for (int p = 0; p < NLANE; p++) begin
                tp_reg[p] <= res_reg42[p] * org_reg[ORG_DEPTH-1][LANE_COL[p]];
            end
            res_reg43  <= res_reg42;
            sing_reg43 <= sing_reg42;
            // stage 44: row sums
            for (int r = 0; r < 3; r++) begin
                ts_reg[r] <= TSW'(tp_reg[r]) + TSW'(tp_reg[3+r]) + TSW'(tp_reg[6+r]);
            end
            res_reg44  <= res_reg43;
            sing_reg44 <= sing_reg43;
        end
    end

    // negate, round half up, shift and saturate the translation
    logic signed [TRW-1:0] trn_sum [3];
    logic signed [TRW-1:0] trn_shf [3];
    word_t                 trn_next [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            trn_sum[r] = RND - TRW'(ts_reg[r]);
            trn_shf[r] = trn_sum[r] >>> FRAC_BITS;
            if (sing_reg44) begin
                trn_next[r] = '0;
            end else if (trn_shf[r] > TRW'(W_MAX)) begin
                trn_next[r] = W_MAX;
            end else if (trn_shf[r] < TRW'(W_MIN)) begin
                trn_next[r] = W_MIN;
            end else begin
                trn_next[r] = word_t'(trn_shf[r][W-1:0]);
            end
        end
    end

    // output register
    word_t out_reg [NFLD];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_ready) begin
            m_tvalid_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && vld_reg[LAST]) begin
            for (int p = 0; p < NLANE; p++) begin
                out_reg[p] <= res_reg44[p];
            end
            for (int r = 0; r < 3; r++) begin
                out_reg[NLANE+r] <= trn_next[r];
            end
        end
    end

    always_comb begin
        for (int f = 0; f < NFLD; f++) begin
            m_tdata[f*W +: W] = out_reg[f];
        end
    end

    // checks on pipeline control and the singular path
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready && vld_reg[LAST]) |-> !s_tready)
        else $error("input taken while full pipeline is stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during stall");

    a_singular_zero_org: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vld_reg[LAST] && sing_reg44) |=> (m_tdata[BUS_W-1:NLANE*W] == '0))
        else $error("singular transform gave nonzero translation");

endmodule

[verif/tb_affine_transform_inverse.sv]
// tb_affine_transform_inverse: self-checking testbench for the affine transform inverter
// depends on ati_pkg and affine_transform_inverse; a scoreboard class predicts each result

module tb_affine_transform_inverse;
    timeunit 1ns;
    timeprecision 1ps;

    import ati_pkg::*;

    typedef logic [BUS_W-1:0] bus_t;
    typedef logic signed [127:0] wide_t;

    localparam int FRAC       = 16;
    localparam int LATENCY    = 46;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    // scoreboard: predicts the inverse of each accepted transform, checks results in order
    class inverse_scoreboard;
        bus_t        pending_q[$];
        logic [16:0] eps;
        int          errors;

        function new();
            eps = EPS_RESET;
            errors = 0;
        endfunction

        static function logic signed [31:0] sat32(wide_t v);
            if (v > wide_t'(QMAX)) return QMAX;
            if (v < wide_t'(QMIN)) return QMIN;
            return v[31:0];
        endfunction

        static function longint ent(bus_t d, int r, int c);
            return longint'($signed(d[(c*3+r)*32 +: 32]));
        endfunction

        function bus_t invert(bus_t d);
            longint cof[9];
            wide_t   cw[9];
            wide_t   det, dmag, half, lim, num, an, q, s, t;
            logic signed [31:0] res[12];
            bus_t    o;
            // exact 2x2 cofactors, wrapped to 64 bits as the datapath keeps them
            cof[0] = ent(d,1,1)*ent(d,2,2) - ent(d,1,2)*ent(d,2,1);
            cof[1] = ent(d,1,2)*ent(d,2,0) - ent(d,1,0)*ent(d,2,2);
            cof[2] = ent(d,1,0)*ent(d,2,1) - ent(d,1,1)*ent(d,2,0);
            cof[3] = ent(d,0,2)*ent(d,2,1) - ent(d,0,1)*ent(d,2,2);
            cof[4] = ent(d,0,0)*ent(d,2,2) - ent(d,0,2)*ent(d,2,0);
            cof[5] = ent(d,0,1)*ent(d,2,0) - ent(d,0,0)*ent(d,2,1);
            cof[6] = ent(d,0,1)*ent(d,1,2) - ent(d,0,2)*ent(d,1,1);
            cof[7] = ent(d,0,2)*ent(d,1,0) - ent(d,0,0)*ent(d,1,2);
            cof[8] = ent(d,0,0)*ent(d,1,1) - ent(d,0,1)*ent(d,1,0);
            for (int i = 0; i < 9; i++) cw[i] = cof[i];
            det = wide_t'(ent(d,0,0)) * cw[0] + wide_t'(ent(d,0,1)) * cw[1]
                + wide_t'(ent(d,0,2)) * cw[2];
            dmag = (det < 0) ? -det : det;
            lim  = wide_t'({1'b0, eps}) <<< (2*FRAC);
            if (dmag == 0 || dmag < lim) begin
                // singular: identity, zero translation
                for (int i = 0; i < 12; i++) res[i] = '0;
                res[0] = 32'sd1 <<< FRAC;
                res[4] = 32'sd1 <<< FRAC;
                res[8] = 32'sd1 <<< FRAC;
            end else begin
                half = dmag >>> 1;
                for (int i = 0; i < 9; i++) begin
                    num = cw[i] <<< (2*FRAC);
                    an  = (num < 0) ? -num : num;
                    q   = (an + half) / dmag;
                    res[i] = sat32(((num < 0) != (det < 0)) ? -q : q);
                end
                // translation from the saturated entries, round half up
                for (int i = 0; i < 3; i++) begin
                    s = wide_t'(res[i])   * wide_t'(ent(d,0,3))
                      + wide_t'(res[3+i]) * wide_t'(ent(d,1,3))
                      + wide_t'(res[6+i]) * wide_t'(ent(d,2,3));
                    t = -s + (wide_t'(1) <<< (FRAC-1));
                    res[9+i] = sat32(t >>> FRAC);
                end
            end
            for (int i = 0; i < 12; i++) o[i*32 +: 32] = res[i];
            return o;
        endfunction

        function void note_input(bus_t d);
            pending_q.insert(pending_q.size(), invert(d));
        endfunction

        function void check_result(bus_t got);
            bus_t exp_v;
            if (pending_q.size() == 0) begin
                $display("%0t: result with nothing expected: %h", $time, got);
                errors++;
                return;
            end
            exp_v = pending_q.pop_front();
            for (int i = 0; i < 12; i++)
                if (exp_v[i*32 +: 32] !== got[i*32 +: 32]) begin
                    $display("%0t: field %0d expected %h actual %h", $time, i,
                             exp_v[i*32 +: 32], got[i*32 +: 32]);
                    errors++;
                end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    bus_t             s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    bus_t             m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [EPS_W-1:0] cfg_data = '0;

    inverse_scoreboard sb = new();
    int cycles = 0;

    affine_transform_inverse dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("affine_transform_inverse test failed");
            $finish;
        end
    end

    // result transactions
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(posedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(0, 99) < 12) ? 1'b0 : 1'b1;
    end

    task automatic send_transform(bus_t d);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.eps = v;
    endtask

    function automatic bus_t pack(logic [31:0] f[12]);
        bus_t d;
        for (int i = 0; i < 12; i++) d[i*32 +: 32] = f[i];
        return d;
    endfunction

    function automatic logic [31:0] rnd_small();
        // about +-4.0 in Q16.16
        return 32'($signed(19'($urandom)));
    endfunction

    function automatic bus_t rnd_transform();
        logic [31:0] f[12];
        int kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 12; i++) f[i] = rnd_small();
        if (kind < 55) begin
            // well-conditioned: strong diagonal
            f[0] = f[0] + 32'h0004_0000;
            f[4] = f[4] - 32'h0004_0000;
            f[8] = f[8] + 32'h0005_0000;
        end else if (kind < 75) begin
            for (int i = 0; i < 12; i++) f[i] = $urandom;
        end else if (kind < 85) begin
            // rank deficient: w equals u or a scaled v
            for (int i = 0; i < 3; i++) f[6+i] = (kind & 1) ? f[i] : f[3+i] <<< 1;
        end else begin
            // tiny entries, determinant around epsilon
            for (int i = 0; i < 9; i++) f[i] = 32'($signed(12'($urandom))) <<< $urandom_range(0, 6);
            f[0] = f[0] + 32'h0000_1000;
            f[4] = f[4] + 32'h0000_1000;
            f[8] = f[8] + 32'h0000_1000;
        end
        return pack(f);
    endfunction

    task automatic run_directed();
        logic [31:0] f[12];
        // zero matrix
        for (int i = 0; i < 12; i++) f[i] = '0;
        send_transform(pack(f));
        // identity with origin
        f[0] = 32'h0001_0000; f[4] = 32'h0001_0000; f[8] = 32'h0001_0000;
        f[9] = 32'h0003_8000; f[10] = 32'hfffe_0000; f[11] = 32'h7fff_ffff;
        send_transform(pack(f));
        // all max, all min
        for (int i = 0; i < 12; i++) f[i] = 32'h7fff_ffff;
        send_transform(pack(f));
        for (int i = 0; i < 12; i++) f[i] = 32'h8000_0000;
        send_transform(pack(f));
        // tiny diagonal: determinant below epsilon, so the result is the identity
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[0] = 32'h0000_0100; f[4] = 32'hffff_ff00; f[8] = 32'h0000_0100;
        f[9] = 32'h8000_0000; f[10] = 32'h7fff_ffff; f[11] = 32'h0001_0000;
        send_transform(pack(f));
        // large diagonal: inverse rounds toward zero entries
        f[0] = 32'h7fff_ffff; f[4] = 32'h8000_0000; f[8] = 32'h7fff_0000;
        send_transform(pack(f));
        // determinant just at and below one in Q16.16 (epsilon 65536 in the second directed run)
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[0] = 32'h0001_0000; f[4] = 32'h0001_0000; f[8] = 32'h0001_0000;
        send_transform(pack(f));
        f[8] = 32'h0000_ffff;
        send_transform(pack(f));
        // swapped columns and a negative diagonal entry, positive determinant
        for (int i = 0; i < 12; i++) f[i] = '0;
        f[1] = 32'h0002_0000; f[3] = 32'h0001_0000; f[8] = 32'hffff_0000;
        f[9] = 32'h0000_8000; f[10] = 32'h0000_8000; f[11] = 32'hffff_8000;
        send_transform(pack(f));
        // alternating bit patterns
        for (int i = 0; i < 12; i++) f[i] = (i & 1) ? 32'h5555_5555 : 32'haaaa_aaaa;
        send_transform(pack(f));
        for (int i = 0; i < 12; i++) f[i] = $urandom;
        send_transform(pack(f));
        for (int i = 0; i < 10; i++) send_transform(rnd_transform());
    endtask

    initial begin
        logic [EPS_W-1:0] eps_set[5];
        eps_set = '{17'd0, 17'd65536, 17'd1, 17'd0, 17'd0};
        eps_set[3] = 17'($urandom_range(0, 65536));
        eps_set[4] = 17'($urandom_range(1, 300));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int p = 0; p < 5; p++) begin
            write_epsilon(eps_set[p]);
            if (p == 1) run_directed();
            for (int n = 0; n < 250; n++) begin
                send_transform(rnd_transform());
                // let the pipeline run dry once mid-phase
                if (p == 2 && n == 120) drain();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("affine_transform_inverse test passed");
        end else begin
            $display("affine_transform_inverse test failed");
        end
        $finish;
    end

endmodule
